// File: hdl/rasobj_pkg.sv
// ----------------------------------------------------------------------------
// rasobj_pkg
// Shared types, widths and the cosine table generator for the Rastrigin
// objective: element word layout between front and back, and fixed constants.
// ----------------------------------------------------------------------------
package rasobj_pkg;

  localparam int X_W    = 16;   // signed Q4.11 element
  localparam int FRAC_W = 11;   // fraction bits of an element
  localparam int SQ_W   = 20;   // (x*x) >> 11, at most 2^19
  localparam int COS_W  = 13;   // round(2048*cos), -2048..2048
  localparam int U_W    = 20;   // term + 10*2048, always in 0..565248
  localparam int FIT_W  = 26;   // fitness result width

  localparam int TEN_FULL = 20480;  // 10 * 2048
  localparam int QUARTER  = 512;    // quarter-wave table span

  localparam logic [63:0] ONE_Q61 = 64'h2000_0000_0000_0000;
  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;

  // Taylor series divisors (2n-1)*(2n) for n = 1..14
  localparam logic [63:0] TaylorDiv [14] = '{
    64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132, 64'd182,
    64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
  };

  // one element word passed from front to back through the queue
  typedef struct packed {
    logic [SQ_W-1:0]   sq;    // (|x|^2) >> 11
    logic [FRAC_W-1:0] frac;  // raw fraction bits, phase source
    logic              keep;  // element counts toward the sum
    logic              last;  // final element of the vector
  } elem_t;

  // (a * b) >> 61, truncated to 64 bits
  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[124:61];
  endfunction

  // round(2048 * cos(pi * k / 1024)) for k in 0..512, elaboration time only
  function automatic logic signed [COS_W-1:0] quarter_entry(input int unsigned k);
    logic [63:0]        theta;
    logic [63:0]        usq;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    logic [63:0]        rounded;
    theta = (PI_Q62 >> 11) * 64'(k);
    usq   = mul_q61(theta, theta);
    mag   = ONE_Q61;
    sum   = ONE_Q61;
    for (int n = 1; n <= 14; n++) begin
      mag = mul_q61(mag, usq) / TaylorDiv[n-1];
      if ((n % 2) == 1) begin
        sum = sum - $signed(mag);
      end else begin
        sum = sum + $signed(mag);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    rounded = (64'(sum) + 64'h0002_0000_0000_0000) >> 50;
    return COS_W'(rounded);
  endfunction

endpackage

// File: hdl/rastrigin_objective.sv
// ----------------------------------------------------------------------------
// rastrigin_objective
// Fixed-point Rastrigin objective over a vector streamed one element per word.
// ----------------------------------------------------------------------------
// Throughput: one element word per clock, sustained while the back pipe is not stalled.
// The last element is written into the queue, then passes the cosine table
//   read, the term register and the result register before out_valid rises.
// The back pipe stalls only when a second result is ready while the first is
//   still held on the output; the 4-entry queue then fills before in_stall.
// Reset (rst, synchronous): empties the queue and pipe, clears sum and counts.
module rastrigin_objective #(
  parameter int MAX_ELEMENTS = 64,
  parameter int PHASE_BITS   = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // element words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rasobj_pkg::X_W-1:0]   x_value,
  input  logic                                last_element,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rasobj_pkg::FIT_W-1:0]        fitness,
  output logic [$clog2(MAX_ELEMENTS + 1)-1:0] element_count,
  output logic                                too_long
);
  import rasobj_pkg::*;

  // front -> queue
  logic  wr_en;
  elem_t wr_data;
  logic  full;
  // queue -> back
  logic  rd_en;
  elem_t rd_data;
  logic  empty;

  // Front: square the magnitude, grab the fraction bits for the phase, and
  // decide whether this element still counts or gets dropped past the limit.
  rasobj_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .x_value      (x_value),
    .last_element (last_element),
    .full         (full),
    .wr_en        (wr_en),
    .wr_data      (wr_data)
  );

  // Queue: decouple the input stall from the result stall.
  rasobj_queue #(
    .DEPTH(4)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .full    (full),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .empty   (empty)
  );

  // Back: look up the cosine, form x^2 - 10*cos + 10*2048 per element (the
  // constant offset folds 10*n*2048 into the sum), accumulate, and on the last
  // element load the result register and clear the running state.
  rasobj_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .PHASE_BITS   (PHASE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .rd_data       (rd_data),
    .rd_en         (rd_en),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fitness       (fitness),
    .element_count (element_count),
    .too_long      (too_long)
  );

endmodule

// File: hdl/rasobj_front.sv
// ----------------------------------------------------------------------------
// rasobj_front
// Accepts elements, squares the magnitude, tags each element as counted or
// dropped against the element limit, and pushes it into the queue.
// ----------------------------------------------------------------------------
module rasobj_front #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [rasobj_pkg::X_W-1:0] x_value,
  input  logic                              last_element,
  input  logic                              full,
  output logic                              wr_en,
  output rasobj_pkg::elem_t                 wr_data
);
  import rasobj_pkg::*;

  localparam int CountW = $clog2(MAX_ELEMENTS + 1);

  logic [CountW-1:0] front_count;
  logic [CountW-1:0] front_count_next;
  logic [X_W-1:0]    mag;
  logic [2*X_W-1:0]  prod;
  logic              keep;

  assign in_stall = full;
  assign wr_en    = in_valid && !full;

  // magnitude of the two's complement element; -32768 maps to 32768
  assign mag  = x_value[X_W-1] ? (~x_value + 1'b1) : x_value;
  assign prod = mag * mag;
  assign keep = (front_count != CountW'(MAX_ELEMENTS));

  always_comb begin
    wr_data.sq   = prod[FRAC_W +: SQ_W];
    wr_data.frac = x_value[FRAC_W-1:0];
    wr_data.keep = keep;
    wr_data.last = last_element;
  end

  always_comb begin
    front_count_next = front_count;
    if (wr_en) begin
      if (last_element) begin
        front_count_next = '0;
      end else if (keep) begin
        front_count_next = front_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_count <= '0;
    end else begin
      front_count <= front_count_next;
    end
  end

endmodule

// File: hdl/rasobj_queue.sv
// ----------------------------------------------------------------------------
// rasobj_queue
// Short first-in first-out queue of element words between front and back.
// ----------------------------------------------------------------------------
module rasobj_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  rasobj_pkg::elem_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output rasobj_pkg::elem_t rd_data,
  output logic              empty
);
  import rasobj_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  elem_t           slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full    = (fill == CntW'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CntW'(wr_en) - CntW'(rd_en);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full && !rd_en))
    else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && empty))
    else $error("queue read while empty");

endmodule

// File: hdl/rasobj_back.sv
// ----------------------------------------------------------------------------
// rasobj_back
// Cosine lookup, term formation and accumulation; drives the result register.
// ----------------------------------------------------------------------------
module rasobj_back #(
  parameter int MAX_ELEMENTS = 64,
  parameter int PHASE_BITS   = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   empty,
  input  rasobj_pkg::elem_t                      rd_data,
  output logic                                   rd_en,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [rasobj_pkg::FIT_W-1:0]           fitness,
  output logic [$clog2(MAX_ELEMENTS + 1)-1:0]    element_count,
  output logic                                   too_long
);
  import rasobj_pkg::*;

  localparam int CountW   = $clog2(MAX_ELEMENTS + 1);
  localparam int RomDepth = 2 ** PHASE_BITS;
  localparam int AccW     = 22;

  typedef logic signed [COS_W-1:0] cos_rom_t [RomDepth];

  function automatic cos_rom_t build_rom();
    cos_rom_t    rom;
    int unsigned k;
    logic [1:0]  quad;
    int unsigned r;
    for (int j = 0; j < RomDepth; j++) begin
      k    = (j << (FRAC_W - PHASE_BITS)) & 2047;
      quad = 2'(k >> 9);
      r    = k & 511;
      case (quad)
        2'd0:    rom[j] = quarter_entry(r);
        2'd1:    rom[j] = -quarter_entry(QUARTER - r);
        2'd2:    rom[j] = -quarter_entry(r);
        default: rom[j] = quarter_entry(QUARTER - r);
      endcase
    end
    return rom;
  endfunction

  localparam cos_rom_t CosRom = build_rom();

  // stage A: table read
  logic                    a_valid;
  logic signed [COS_W-1:0] a_cos;
  logic [SQ_W-1:0]         a_sq;
  logic                    a_keep;
  logic                    a_last;
  // stage B: offset term
  logic                    b_valid;
  logic [U_W-1:0]          b_u;
  logic                    b_keep;
  logic                    b_last;
  // accumulator
  logic [FIT_W-1:0]        acc;
  logic [FIT_W-1:0]        acc_next;
  logic [CountW-1:0]       count;
  logic [CountW-1:0]       count_next;
  logic                    ovf;
  logic                    ovf_next;

  logic                    advance;
  logic                    load;
  logic signed [AccW-1:0]  cos_ext;
  logic signed [AccW-1:0]  u_full;

  // hold the whole pipe only when a second result meets a waiting one
  assign advance = !(b_valid && b_last && out_valid && out_stall);
  assign rd_en   = advance && !empty;
  assign load    = advance && b_valid && b_last;

  // per-element value: x^2 - 10*cos + 10*2048, never negative
  assign cos_ext = AccW'(a_cos);
  assign u_full  = $signed({2'b00, a_sq}) + AccW'(TEN_FULL)
                 - ((cos_ext <<< 3) + (cos_ext <<< 1));

  always_comb begin
    acc_next   = acc + (b_keep ? FIT_W'(b_u) : '0);
    count_next = count + CountW'(b_keep);
    ovf_next   = ovf | !b_keep;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_cos  <= CosRom[rd_data.frac[FRAC_W-1 -: PHASE_BITS]];
      a_sq   <= rd_data.sq;
      a_keep <= rd_data.keep;
      a_last <= rd_data.last;
      b_u    <= u_full[U_W-1:0];
      b_keep <= a_keep;
      b_last <= a_last;
    end
    if (load) begin
      fitness       <= acc_next;
      element_count <= count_next;
      too_long      <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      acc       <= '0;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        a_valid <= !empty;
        b_valid <= a_valid;
        if (b_valid) begin
          if (b_last) begin
            acc   <= '0;
            count <= '0;
            ovf   <= 1'b0;
          end else begin
            acc   <= acc_next;
            count <= count_next;
            ovf   <= ovf_next;
          end
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (element_count != '0) && (element_count <= CountW'(MAX_ELEMENTS)))
    else $error("result element count out of range");

  a_too_long_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && too_long) |-> (element_count == CountW'(MAX_ELEMENTS)))
    else $error("overflow flagged below the element limit");

  a_acc_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(MAX_ELEMENTS))
    else $error("running element count past the limit");

  a_ovf_at_cap: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == CountW'(MAX_ELEMENTS)))
    else $error("overflow set before the limit was reached");

endmodule

// File: test/rastrigin_objective_tb.sv
// ----------------------------------------------------------------------------
// rastrigin_objective_tb
// Self-checking bench for the fixed-point Rastrigin objective. Element words
// are streamed from a queue by a clocked driver. A local predictor keeps its
// own running sum, count and overflow flag, and builds its own cosine table
// from real math. A clocked monitor compares each result word with the oldest
// predicted score. Both sides throttle in random bursts. One phase holds the
// output long enough to back up the block, and the sender drains between
// phases.
// ----------------------------------------------------------------------------
module rastrigin_objective_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rasobj_pkg::*;

  localparam int MAX_ELEMENTS   = 64;
  localparam int PHASE_BITS     = 10;
  localparam int COUNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int HOLD_CYCLES    = 300;   // long output hold-off
  localparam int DRAIN_CYCLES   = 20;    // settle time after the last result
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake
  localparam real PI_VALUE      = 3.14159265358979323846;

  // one element word waiting to be driven
  typedef struct {
    logic signed [X_W-1:0] x;
    logic                  last;
  } element_word_t;

  // one predicted result word
  typedef struct {
    logic [FIT_W-1:0]   fitness;
    logic [COUNT_W-1:0] count;
    logic               too_long;
  } score_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [X_W-1:0] x_value = '0;
  logic                  last_element = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FIT_W-1:0]      fitness;
  logic [COUNT_W-1:0]    element_count;
  logic                  too_long;

  rastrigin_objective #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .PHASE_BITS   (PHASE_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .x_value       (x_value),
    .last_element  (last_element),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fitness       (fitness),
    .element_count (element_count),
    .too_long      (too_long)
  );

  always #5 clk = ~clk;

  // stimulus and expectations
  element_word_t element_feed[$];
  score_t        due_scores[$];

  // predictor state: mirrors the block's accumulator
  int quarter_wave [0:QUARTER];
  int vector_sum;
  int vector_count;
  bit vector_overflow;

  // control shared between the sequencer and the two clocked sides
  bit quiet_run;         // no idling on either side
  int hold_ticket;       // bumped to request one long output hold-off
  int hold_served;
  int mismatches;
  int words_taken;
  int scores_checked;
  int overlong_scores;
  int items_queued;

  // Build round(2048*cos) over one quarter wave; the other quadrants fold
  // back onto it by symmetry, exactly as a quarter-wave ROM does.
  initial begin
    for (int k = 0; k <= QUARTER; k++) begin
      quarter_wave[k] = $rtoi(2048.0 * $cos(PI_VALUE * k / 1024.0) + 0.5);
    end
  end

  // Cosine of the phase held in the fraction bits, in Q.11.
  function automatic int cos_q11(input logic [FRAC_W-1:0] frac);
    logic [FRAC_W-1:0] phase;
    logic [8:0]        offset;
    phase  = (frac >> (FRAC_W - PHASE_BITS)) << (FRAC_W - PHASE_BITS);
    offset = phase[8:0];
    case (phase[10:9])
      2'd0:    return quarter_wave[offset];
      2'd1:    return -quarter_wave[QUARTER - offset];
      2'd2:    return -quarter_wave[offset];
      default: return quarter_wave[QUARTER - offset];
    endcase
  endfunction

  // Fold one accepted element into the running vector; on the last element
  // queue the predicted score and clear the vector.
  task automatic absorb_element(input logic signed [X_W-1:0] x, input logic last);
    int     magnitude;
    int     term;
    longint total;
    score_t score;
    magnitude = (x < 0) ? -int'(x) : int'(x);
    term = ((magnitude * magnitude) >> FRAC_W) - 10 * cos_q11(x[FRAC_W-1:0]);
    // drop elements past the vector limit, just flag them
    if (vector_count < MAX_ELEMENTS) begin
      vector_sum   += term;
      vector_count += 1;
    end else begin
      vector_overflow = 1'b1;
    end
    if (last) begin
      total = longint'(vector_sum) + longint'(TEN_FULL) * vector_count;
      if (total < 0) begin
        total = 0;
      end
      score.fitness  = FIT_W'(total);
      score.count    = COUNT_W'(vector_count);
      score.too_long = vector_overflow;
      due_scores.push_back(score);
      vector_sum      = 0;
      vector_count    = 0;
      vector_overflow = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer element words from the feed, idling in random bursts.
  // A stalled word holds still; valid is assigned once per edge.
  // --------------------------------------------------------------------------
  int send_gap;

  always @(posedge clk) begin : driver
    element_word_t w;
    if (rst) begin
      in_valid     <= 1'b0;
      x_value      <= '0;
      last_element <= 1'b0;
      send_gap     <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_element(x_value, last_element);
        words_taken++;
      end
      // hold the word while the block stalls; otherwise pick the next move
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (element_feed.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet_run && $urandom_range(0, 11) == 0) begin
          // start an idle burst, this one included
          send_gap <= $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else begin
          w = element_feed.pop_front();
          x_value      <= w.x;
          last_element <= w.last;
          in_valid     <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result word against the oldest score, and
  // throttle the output with random stall bursts or a long hold-off.
  // --------------------------------------------------------------------------
  int stall_left;
  int hold_left;

  always @(posedge clk) begin : monitor
    score_t want;
    if (rst) begin
      out_stall   <= 1'b0;
      stall_left  <= 0;
      hold_left   <= 0;
      hold_served <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_scores.size() == 0) begin
          $display("%0t: result word with nothing expected: fitness %0d count %0d too_long %0b",
                   $time, fitness, element_count, too_long);
          mismatches++;
        end else begin
          want = due_scores.pop_front();
          scores_checked++;
          if (fitness !== want.fitness) begin
            $display("%0t: fitness mismatch: expected %0d actual %0d",
                     $time, want.fitness, fitness);
            mismatches++;
          end
          if (element_count !== want.count) begin
            $display("%0t: element_count mismatch: expected %0d actual %0d",
                     $time, want.count, element_count);
            mismatches++;
          end
          if (too_long !== want.too_long) begin
            $display("%0t: too_long mismatch: expected %0b actual %0b",
                     $time, want.too_long, too_long);
            mismatches++;
          end
          if (want.too_long) begin
            overlong_scores++;
          end
        end
      end
      // a new ticket starts a long hold-off, counted here
      if (hold_ticket != hold_served) begin
        hold_served <= hold_ticket;
        hold_left   <= HOLD_CYCLES - 1;
        out_stall   <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!quiet_run && $urandom_range(0, 11) == 0) begin
        stall_left <= $urandom_range(0, 15);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no word moves on either side for too long.
  // --------------------------------------------------------------------------
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d scores outstanding",
               $time, idle_cycles, due_scores.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: fill the feed phase by phase. All polling runs on the falling
  // edge so it never races the clocked sides.
  // --------------------------------------------------------------------------
  logic signed [X_W-1:0] corner_values [12] = '{
    16'sh0000, 16'sh0001, -16'sh0001, 16'sh7FFF, -16'sh8000, 16'sh0200,
    16'sh0400, 16'sh0600, 16'sh07FF, 16'sh0800, -16'sh0800, 16'sh7800
  };

  function automatic logic signed [X_W-1:0] pick_element();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) begin
      // typical search box, about +-5.12
      return X_W'(int'($urandom_range(0, 20972)) - 10486);
    end else if (roll < 8) begin
      return X_W'($urandom);
    end else begin
      return corner_values[$urandom_range(0, 11)];
    end
  endfunction

  // queue one vector of the given length with random content
  task automatic add_vector(input int len);
    element_word_t w;
    for (int i = 0; i < len; i++) begin
      w.x    = pick_element();
      w.last = (i == len - 1);
      element_feed.push_back(w);
      items_queued++;
    end
  endtask

  task automatic add_word(input logic signed [X_W-1:0] x, input logic last);
    element_word_t w;
    w.x    = x;
    w.last = last;
    element_feed.push_back(w);
    items_queued++;
  endtask

  // mostly short vectors, some long, a few past the limit
  function automatic int pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return $urandom_range(1, 8);
    end else if (roll < 90) begin
      return $urandom_range(9, 40);
    end else if (roll < 97) begin
      return $urandom_range(41, MAX_ELEMENTS);
    end else begin
      return $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 16);
    end
  endfunction

  // wait until every word is sent and every score has come back
  task automatic wait_drained();
    @(negedge clk);
    while (element_feed.size() != 0 || in_valid || due_scores.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    int target;

    vector_sum      = 0;
    vector_count    = 0;
    vector_overflow = 1'b0;
    quiet_run       = 1'b0;
    hold_ticket     = 0;
    mismatches      = 0;
    words_taken     = 0;
    scores_checked  = 0;
    overlong_scores = 0;
    items_queued    = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: single-element vectors at the extremes, zero and +-1 LSB
    add_word(16'sh0000, 1'b1);
    add_word(16'sh7FFF, 1'b1);
    add_word(-16'sh8000, 1'b1);
    add_word(-16'sh0001, 1'b1);
    add_word(16'sh0001, 1'b1);
    // one vector through the upper three cosine quadrants, negative element last
    add_word(16'sh0200, 1'b0);
    add_word(16'sh0400, 1'b0);
    add_word(16'sh0600, 1'b0);
    add_word(-16'sh0200, 1'b1);
    // quadrant edges, odd fraction bit dropped by the phase index
    add_word(16'sh01FF, 1'b0);
    add_word(16'sh0201, 1'b0);
    add_word(16'sh05FF, 1'b0);
    add_word(16'sh07FF, 1'b1);
    // whole numbers, positive and negative, all at cosine peak
    add_word(16'sh0800, 1'b0);
    add_word(-16'sh0800, 1'b0);
    add_word(16'sh7800, 1'b0);
    add_word(-16'sh7800, 1'b1);
    // largest terms summed
    add_word(-16'sh8000, 1'b0);
    add_word(-16'sh8000, 1'b0);
    add_word(16'sh7C00, 1'b1);
    wait_drained();

    // Back-pressure: hold the output for a long stretch while a run of
    // one-element vectors keeps coming, so the queue fills and stalls input.
    hold_ticket++;
    for (int i = 0; i < 40; i++) begin
      add_vector(1);
    end
    wait_drained();

    // Random, first half: open with a full-length and an overlong vector
    add_vector(MAX_ELEMENTS);
    add_vector(MAX_ELEMENTS + 6);
    target = items_queued + 450;
    while (items_queued < target) begin
      add_vector(pick_length());
    end
    // sender pauses here until every score is back
    wait_drained();

    // Random, second half
    target = items_queued + 450;
    while (items_queued < target) begin
      add_vector(pick_length());
    end
    wait_drained();

    // Final stretch: full rate on both sides, no idling
    quiet_run = 1'b1;
    target = items_queued + 160;
    while (items_queued < target) begin
      add_vector($urandom_range(1, 12));
    end
    add_vector(MAX_ELEMENTS + 3);
    wait_drained();

    // let any stray result word show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_scores.size() != 0) begin
      $display("%0t: %0d predicted scores never arrived", $time, due_scores.size());
      mismatches += due_scores.size();
    end

    $display("Streamed %0d element words, checked %0d vector scores (%0d overlong).",
             words_taken, scores_checked, overlong_scores);
    $display("Included extreme elements, every cosine quadrant, a long output hold-off.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
